@@ rtl/core/lsws_pkg.sv @@
// Shared codes, field layout and controller/datapath interface types for the LIFO stack.
`timescale 1ns / 1ps

package lsws_pkg;

	// operation codes
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	localparam int IN_W  = 40;
	localparam int OUT_W = 88;

	typedef struct packed {
		logic capture;
		logic push;
		logic pop;
		logic underflow;
		logic overflow;
		logic top_load;
		logic srch_init;
		logic srch_step;
		logic srch_hit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       empty;
		logic       full;
		logic       hit;
		logic       last;
		logic       out_free;
	} sts_t;

endpackage

@@ rtl/core/lsws_ctrl.sv @@
// Controller state machine for the LIFO stack: sequences push, pop and search.
`timescale 1ns / 1ps

module lsws_ctrl
	import lsws_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		POP_TOP,
		SRCH,
		DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign s_tready = (state_q == IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = DONE;
					case (sts.op)
						OP_PUSH: begin
							if (sts.full) begin
								cmd.overflow = 1'b1;
							end else begin
								cmd.push = 1'b1;
							end
						end
						OP_POP: begin
							if (sts.empty) begin
								cmd.underflow = 1'b1;
							end else begin
								cmd.pop   = 1'b1;
								state_nxt = POP_TOP;
							end
						end
						OP_SEARCH: begin
							if (!sts.empty) begin
								cmd.srch_init = 1'b1;
								state_nxt     = SRCH;
							end
						end
						default: begin
							state_nxt = DONE;
						end
					endcase
				end
			end
			POP_TOP: begin
				// new top word arrives from the store read issued by the pop
				cmd.top_load = 1'b1;
				state_nxt    = DONE;
			end
			SRCH: begin
				if (sts.hit) begin
					cmd.srch_hit = 1'b1;
					state_nxt    = DONE;
				end else if (sts.last) begin
					state_nxt = DONE;
				end else begin
					cmd.srch_step = 1'b1;
				end
			end
			DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = IDLE;
				end
			end
			default: begin
				state_nxt = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ rtl/core/lsws_dpath.sv @@
// Datapath for the LIFO stack: entry store, fill count, top register, search walk, result word.
`timescale 1ns / 1ps

module lsws_dpath
	import lsws_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [31:0]      mem [STACK_DEPTH];
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    ptr_q;
	logic [CW-1:0]    dist_q;
	logic [CW-1:0]    dist_s1;
	logic             rd_vld_s1;
	logic [31:0]      rdata_s1;
	logic [AW-1:0]    rd_addr;
	logic [31:0]      key_q;
	logic [31:0]      top_q;
	logic [1:0]       res_status_q;
	logic [31:0]      res_popped_q;
	logic             res_found_q;
	logic [5:0]       res_dist_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [1:0]       in_op;
	logic [31:0]      in_value;
	logic             empty;
	logic [31:0]      top_out;

	assign in_op    = s_tdata[1:0];
	assign in_value = s_tdata[33:2];
	assign empty    = (count_q == '0);
	assign top_out  = empty ? 32'd0 : top_q;

	assign sts.op       = in_op;
	assign sts.empty    = empty;
	assign sts.full     = (count_q == CW'(STACK_DEPTH));
	assign sts.hit      = rd_vld_s1 && (rdata_s1 == key_q);
	assign sts.last     = rd_vld_s1 && (dist_s1 == (count_q - CW'(1)));
	assign sts.out_free = !m_tvalid_q || m_tready;

	// a pop reads the word below the current top, which becomes the new top
	assign rd_addr = cmd.pop ? AW'(count_q - CW'(2)) : ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[count_q[AW-1:0]] <= in_value;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			rd_vld_s1 <= cmd.srch_step;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q        <= in_value;
			res_status_q <= ST_OK;
			res_popped_q <= 32'd0;
			res_found_q  <= 1'b0;
			res_dist_q   <= 6'd0;
		end
		if (cmd.overflow) begin
			res_status_q <= ST_OVERFLOW;
		end
		if (cmd.underflow) begin
			res_status_q <= ST_UNDERFLOW;
		end
		if (cmd.pop) begin
			res_popped_q <= top_q;
		end
		if (cmd.push) begin
			top_q <= in_value;
		end else if (cmd.top_load) begin
			top_q <= rdata_s1;
		end
		// search walks down from the top, one read a cycle; the registered read data is compared in the next cycle
		if (cmd.srch_init) begin
			ptr_q  <= AW'(count_q - CW'(1));
			dist_q <= '0;
		end else if (cmd.srch_step) begin
			ptr_q  <= ptr_q - AW'(1);
			dist_q <= dist_q + CW'(1);
		end
		dist_s1 <= dist_q;
		if (cmd.srch_hit) begin
			res_found_q <= 1'b1;
			res_dist_q  <= 6'(dist_s1);
		end
		if (cmd.out_load) begin
			m_tdata_q <= {
				7'd0,
				7'(count_q),
				empty,
				top_out,
				res_dist_q,
				res_found_q,
				res_popped_q,
				res_status_q
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/core/lifo_stack_with_search_unit.sv @@
// Top level of the LIFO stack with search: controller plus datapath.
`timescale 1ns / 1ps

// Bounded last-in-first-out stack of signed 32-bit words, STACK_DEPTH entries deep.
// Each input word is a push, a pop or a search; each gives exactly one result word
// with the status, the popped value, the search result (distance from the top of the
// nearest match, top at zero), the top value, the empty flag and the occupancy.
// Pop on an empty stack reports underflow and push on a full stack reports overflow;
// neither changes the stack. Operation code three changes nothing and reports state.
// Steps, from input accept to result load with the output free: a push goes straight to
// the result load; a pop first takes one store read to fetch the new top; a search issues
// the first read, then examines one entry per cycle from the store's single read port
// until a match or the last entry. A search on an empty stack and operation code three go
// straight to the result load. The next word is taken the cycle after the load. One word
// is worked on at a time; the result register lets the next word in while a result still
// waits on the output.

module lifo_stack_with_search_unit
	import lsws_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // op[1:0], value[33:2], zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // status[1:0], popped_value[33:2], found[34],
	                                    // distance[40:35], top_value[72:41],
	                                    // is_empty[73], occupancy[80:74], zero pad
);

	cmd_t cmd;
	sts_t sts;

	lsws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsws_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ verif/lifo_stack_with_search_unit_test.sv @@
// Self-checking testbench for the LIFO stack with search: stimulus, predictor, checks.
`timescale 1ns / 1ps

module lifo_stack_with_search_unit_test
	import lsws_pkg::*;
;

	localparam int STACK_DEPTH = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = STACK_DEPTH + 40;
	localparam logic [1:0] OP_NOP = 2'd3;

	// result word layout, status in the lowest bits
	typedef struct packed {
		logic [6:0]  occupancy;
		logic        is_empty;
		logic [31:0] top_value;
		logic [5:0]  distance;
		logic        found;
		logic [31:0] popped_value;
		logic [1:0]  status;
	} stack_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// predictor state
	logic [31:0]   stack_mem [STACK_DEPTH];
	int unsigned   depth_now = 0;
	stack_result_t pending_results [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int n_errors = 0;
	int stall_cycles = 0;
	int n_push = 0, n_pop = 0, n_search = 0, n_nop = 0;
	int n_overflow = 0, n_underflow = 0, n_hits = 0, n_checked = 0;

	lifo_stack_with_search_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// work out the result of one accepted word and update the stack copy
	task automatic predict_stack_op(input logic [1:0] op, input logic [31:0] val);
		stack_result_t r;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_PUSH: begin
				n_push++;
				if (depth_now >= STACK_DEPTH) begin
					r.status = ST_OVERFLOW;
					n_overflow++;
				end else begin
					stack_mem[depth_now] = val;
					depth_now++;
				end
			end
			OP_POP: begin
				n_pop++;
				if (depth_now == 0) begin
					r.status = ST_UNDERFLOW;
					n_underflow++;
				end else begin
					depth_now--;
					r.popped_value = stack_mem[depth_now];
				end
			end
			OP_SEARCH: begin
				n_search++;
				for (int k = 0; k < depth_now; k++) begin
					if (!r.found && stack_mem[depth_now - 1 - k] == val) begin
						r.found = 1'b1;
						r.distance = k[5:0];
					end
				end
				if (r.found)
					n_hits++;
			end
			default: n_nop++;
		endcase
		if (depth_now != 0)
			r.top_value = stack_mem[depth_now - 1];
		r.is_empty = (depth_now == 0);
		r.occupancy = depth_now[6:0];
		pending_results.push_back(r);
	endtask

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [1:0] op, input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - 34){1'b0}}, val, op};
		do
			@(posedge clk);
		while (!s_tready);
		predict_stack_op(op, val);
		@(negedge clk);
	endtask

	task automatic test_empty_stack;
		send_word(OP_POP, 32'h0000_0000);
		send_word(OP_SEARCH, 32'h0000_0000);
		send_word(OP_NOP, 32'hffff_ffff);
		send_word(OP_SEARCH, 32'hffff_ffff);
	endtask

	// extreme values, a duplicate so that the nearest match matters, hit and miss
	task automatic test_value_extremes;
		send_word(OP_PUSH, 32'h8000_0000);
		send_word(OP_PUSH, 32'h7fff_ffff);
		send_word(OP_PUSH, 32'h0000_0000);
		send_word(OP_PUSH, 32'hffff_ffff);
		send_word(OP_PUSH, 32'h7fff_ffff);
		send_word(OP_SEARCH, 32'h7fff_ffff);
		send_word(OP_SEARCH, 32'h8000_0000);
		send_word(OP_SEARCH, 32'h0000_0000);
		send_word(OP_SEARCH, 32'h1234_5678);
		send_word(OP_NOP, 32'haaaa_aaaa);
		for (int i = 0; i < 5; i++)
			send_word(OP_POP, 32'h5555_5555);
		send_word(OP_POP, 32'hffff_ffff);
		send_word(OP_SEARCH, 32'h7fff_ffff);
	endtask

	// fill to the top, overflow, search both ends, then drain to underflow
	task automatic test_fill_overflow;
		while (depth_now < STACK_DEPTH)
			send_word(OP_PUSH, $urandom);
		send_word(OP_PUSH, $urandom);
		send_word(OP_PUSH, 32'h8000_0000);
		send_word(OP_SEARCH, stack_mem[0]);
		send_word(OP_SEARCH, stack_mem[STACK_DEPTH - 1]);
		send_word(OP_NOP, $urandom);
		while (depth_now != 0)
			send_word(OP_POP, $urandom);
		send_word(OP_POP, $urandom);
	endtask

	// random walk towards a fresh target depth every few words
	task automatic test_random_ops(input int n_words);
		int target;
		int roll;
		logic [1:0] op;
		logic [31:0] val;
		target = 0;
		for (int i = 0; i < n_words; i++) begin
			if (i % 20 == 0)
				target = $urandom_range(STACK_DEPTH);
			roll = $urandom_range(99);
			if (roll < 5)
				op = OP_NOP;
			else if (roll < 35)
				op = OP_SEARCH;
			else if (depth_now < target)
				op = (roll < 85) ? OP_PUSH : OP_POP;
			else
				op = (roll < 85) ? OP_POP : OP_PUSH;
			roll = $urandom_range(99);
			if (op == OP_SEARCH && depth_now != 0 && roll < 60)
				val = stack_mem[$urandom_range(depth_now - 1)];
			else if (roll < 80)
				val = $urandom;
			else begin
				// small pool so duplicates pile up in the stack
				case ($urandom_range(3))
					0: val = 32'h8000_0000;
					1: val = 32'h7fff_ffff;
					2: val = 32'hffff_ffff;
					default: val = 32'h0000_0007;
				endcase
			end
			send_word(op, val);
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 74;
		test_empty_stack();
		test_value_extremes();
		test_random_ops(100);

		send_idle_pct = 74;
		recv_idle_pct = 22;
		test_fill_overflow();
		test_random_ops(70);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_ops(80);

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d push (%0d overflow), %0d pop (%0d underflow),",
			n_checked, n_push, n_overflow, n_pop, n_underflow);
		$display("%0d search (%0d hits), %0d no-op; stack taken from empty to full and back.",
			n_search, n_hits, n_nop);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		stack_result_t got;
		stack_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(stack_result_t)-1:0];
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result word, expected none, got %h",
					$time, m_tdata);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("popped_value", want.popped_value, got.popped_value);
				check_field("found", 32'(want.found), 32'(got.found));
				check_field("distance", 32'(want.distance), 32'(got.distance));
				check_field("top_value", want.top_value, got.top_value);
				check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
				check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t ns: timeout, %0d results still outstanding",
				$time, pending_results.size());
			$display("Mismatches found");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

endmodule
